>>> hdl/gop_pkg.sv
package gop_pkg;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_ENDS,
    PH_ILEN,
    PH_INSTR,
    PH_FLAGS,
    PH_RPT,
    PH_X,
    PH_Y,
    PH_DRAIN,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    E_IN,
    E_RPT,
    E_FRD,
    E_FCHK,
    E_FIN,
    E_EMIT
  } eng_t;

  typedef logic [1:0] status_t;

  localparam status_t STAT_POINT     = 2'd0;
  localparam status_t STAT_COMPOSITE = 2'd1;
  localparam status_t STAT_OVERFLOW  = 2'd2;
  localparam status_t STAT_TRUNCATED = 2'd3;

  // flag bit positions
  localparam int FB_ON     = 0;
  localparam int FB_XSHORT = 1;
  localparam int FB_YSHORT = 2;
  localparam int FB_RPT    = 3;
  localparam int FB_XSAME  = 4;
  localparam int FB_YSAME  = 5;

  localparam int HEADER_LAST = 9;
  localparam int FLAG_W      = 6;
  localparam int COORD_W     = 16;
  localparam int PT_W        = 17;

endpackage

>>> hdl/gop_ram.sv
module gop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/glyph_outline_point_decoder.sv
// header, end index, length, instruction and flag words are taken in the input state, and
// end_of_data adds the finish state; a word that ends the flags or a delta starts a settle
// walk of flag reads and checks that skips zero-delta points and hands x over to y
// a repeat count copies the last flag into the following points, then settles if it ends the flags
// a result is loaded from the finish or emit state; output stalls hold the input
// synchronous reset returns to the record header with nothing in flight
module glyph_outline_point_decoder #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CONTOURS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               start_glyph,
  input  logic               end_of_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic [9:0]         point_number,
  output logic               on_curve,
  output logic               contour_end,
  output logic               last_point,
  output logic [1:0]         status
);

  localparam int CU_W = $clog2(MAX_POINTS + 1);
  localparam int PA_W = $clog2(MAX_POINTS);
  localparam int CC_W = $clog2(MAX_CONTOURS + 1);
  localparam int CA_W = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam int PT_W = gop_pkg::PT_W;
  localparam int CW   = gop_pkg::COORD_W;
  localparam int FW   = gop_pkg::FLAG_W;

  gop_pkg::eng_t   eng, eng_next, route;
  gop_pkg::phase_t phase, phase_next;
  logic [15:0]     byte_step, byte_step_next;
  logic [7:0]      high_byte, high_byte_next;
  logic [15:0]     hdr_count, hdr_count_next;
  logic [CC_W-1:0] contour_total, contour_total_next;
  logic [PT_W-1:0] point_total, point_total_next;
  logic [15:0]     instr_remaining, instr_remaining_next;
  logic [7:0]      repeat_left, repeat_left_next;
  logic [CU_W-1:0] cursor, cursor_next;
  logic [CW-1:0]   coord_running, coord_running_next;
  logic [CC_W-1:0] contour_cursor, contour_cursor_next;
  logic [CU_W-1:0] emit_next, emit_next_next;
  logic [FW-1:0]   last_flag, last_flag_next;
  logic [FW-1:0]   cur_flag, cur_flag_next;
  logic            item_eod, item_eod_next;
  logic            item_stat_v, item_stat_v_next;
  gop_pkg::status_t item_stat, item_stat_next;

  logic            out_load;
  logic [CW-1:0]   ld_x, ld_y;
  logic [9:0]      ld_num;
  logic            ld_on, ld_ce, ld_last;
  gop_pkg::status_t ld_stat;
  logic            out_free;

  logic            flag_we;
  logic [PA_W-1:0] flag_waddr;
  logic [FW-1:0]   flag_wdata, flag_rdata;
  logic            x_we, y_we;
  logic [PA_W-1:0] pt_waddr;
  logic [CW:0]     x_wdata, x_rdata;
  logic [CW-1:0]   y_wdata, y_rdata;
  logic            end_we;
  logic [CA_W-1:0] end_waddr;
  logic [15:0]     end_wdata, end_rdata;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (eng == gop_pkg::E_IN);

  gop_ram #(.WIDTH(FW), .DEPTH(MAX_POINTS)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(cursor[PA_W-1:0]), .rdata(flag_rdata)
  );

  gop_ram #(.WIDTH(CW + 1), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(pt_waddr), .wdata(x_wdata),
    .raddr(emit_next[PA_W-1:0]), .rdata(x_rdata)
  );

  gop_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(pt_waddr), .wdata(y_wdata),
    .raddr(emit_next[PA_W-1:0]), .rdata(y_rdata)
  );

  gop_ram #(.WIDTH(16), .DEPTH(MAX_CONTOURS)) u_end_ram (
    .clk(clk), .we(end_we), .waddr(end_waddr), .wdata(end_wdata),
    .raddr(contour_cursor[CA_W-1:0]), .rdata(end_rdata)
  );

  // datapath: byte handling, settle walk, emission
  always_comb begin
    gop_pkg::phase_t ph;
    logic [15:0]     bs;
    logic [7:0]      hb;
    logic [15:0]     hc;
    logic [CC_W-1:0] ct;
    logic [PT_W-1:0] pt;
    logic [15:0]     ir;
    logic [CU_W-1:0] cu;
    logic [CW-1:0]   cr;
    logic [CW-1:0]   delta;
    logic [15:0]     e;
    logic [FW-1:0]   f;
    logic            sh, sm, do_store, st_v, ce;
    gop_pkg::status_t st;

    phase_next           = phase;
    byte_step_next       = byte_step;
    high_byte_next       = high_byte;
    hdr_count_next       = hdr_count;
    contour_total_next   = contour_total;
    point_total_next     = point_total;
    instr_remaining_next = instr_remaining;
    repeat_left_next     = repeat_left;
    cursor_next          = cursor;
    coord_running_next   = coord_running;
    contour_cursor_next  = contour_cursor;
    emit_next_next       = emit_next;
    last_flag_next       = last_flag;
    cur_flag_next        = cur_flag;
    item_eod_next        = item_eod;
    item_stat_v_next     = item_stat_v;
    item_stat_next       = item_stat;
    route                = eng;

    flag_we    = 1'b0;
    flag_waddr = cursor[PA_W-1:0];
    flag_wdata = last_flag;
    x_we       = 1'b0;
    y_we       = 1'b0;
    pt_waddr   = cursor[PA_W-1:0];
    x_wdata    = {1'b0, coord_running};
    y_wdata    = coord_running;
    end_we     = 1'b0;
    end_waddr  = byte_step[CA_W:1];
    end_wdata  = 16'd0;

    out_load = 1'b0;
    ld_x     = '0;
    ld_y     = '0;
    ld_num   = '0;
    ld_on    = 1'b0;
    ld_ce    = 1'b0;
    ld_last  = 1'b1;
    ld_stat  = gop_pkg::STAT_POINT;

    ph = phase; bs = byte_step; hb = high_byte; hc = hdr_count; ct = contour_total;
    pt = point_total; ir = instr_remaining; cu = cursor; cr = coord_running;
    delta = '0; e = '0; f = cur_flag; sh = 1'b0; sm = 1'b0; do_store = 1'b0;
    st_v = 1'b0; st = gop_pkg::STAT_POINT; ce = 1'b0;

    case (eng)
      gop_pkg::E_IN: begin
        if (in_valid) begin
          if (start_glyph) begin
            ph = gop_pkg::PH_HEADER; bs = '0; hb = '0; hc = '0; ct = '0; pt = '0;
            ir = '0; cu = '0; cr = '0;
            contour_cursor_next = '0;
            emit_next_next = '0;
          end
          route = gop_pkg::E_IN;
          case (ph)
            gop_pkg::PH_HEADER: begin
              if (bs == 16'd0) begin
                hb = data_byte;
              end else if (bs == 16'd1) begin
                hc = {hb, data_byte};
              end
              if (bs == 16'(gop_pkg::HEADER_LAST)) begin
                if (hc == 16'd0 || hc[15]) begin
                  st_v = 1'b1; st = gop_pkg::STAT_COMPOSITE; ph = gop_pkg::PH_IDLE;
                end else if (32'(hc) > 32'(MAX_CONTOURS)) begin
                  st_v = 1'b1; st = gop_pkg::STAT_OVERFLOW; ph = gop_pkg::PH_IDLE;
                end else begin
                  ct = CC_W'(hc); ph = gop_pkg::PH_ENDS; bs = '0;
                end
              end else begin
                bs = bs + 16'd1;
              end
            end
            gop_pkg::PH_ENDS: begin
              if (!bs[0]) begin
                hb = data_byte;
              end else begin
                e = {hb, data_byte};
                end_we = 1'b1;
                end_waddr = bs[CA_W:1];
                end_wdata = e;
                if (PT_W'(e) + PT_W'(1) > pt) begin
                  pt = PT_W'(e) + PT_W'(1);
                end
              end
              if (PT_W'(bs) + PT_W'(1) >= PT_W'({ct, 1'b0})) begin
                if (32'(pt) > 32'(MAX_POINTS)) begin
                  st_v = 1'b1; st = gop_pkg::STAT_OVERFLOW; ph = gop_pkg::PH_IDLE;
                end else begin
                  ph = gop_pkg::PH_ILEN;
                end
                bs = '0;
              end else begin
                bs = bs + 16'd1;
              end
            end
            gop_pkg::PH_ILEN: begin
              if (bs == 16'd0) begin
                hb = data_byte; bs = 16'd1;
              end else begin
                ir = {hb, data_byte}; bs = '0;
                ph = (ir != 16'd0) ? gop_pkg::PH_INSTR : gop_pkg::PH_FLAGS;
              end
            end
            gop_pkg::PH_INSTR: begin
              ir = ir - 16'd1;
              if (ir == 16'd0) begin
                ph = gop_pkg::PH_FLAGS;
              end
            end
            gop_pkg::PH_FLAGS: begin
              if (PT_W'(cu) < pt) begin
                flag_we = 1'b1;
                flag_waddr = cu[PA_W-1:0];
                flag_wdata = data_byte[FW-1:0];
                last_flag_next = data_byte[FW-1:0];
                cu = cu + CU_W'(1);
              end
              if (data_byte[gop_pkg::FB_RPT]) begin
                ph = gop_pkg::PH_RPT;
              end else if (PT_W'(cu) >= pt) begin
                ph = gop_pkg::PH_X; cu = '0; cr = '0; bs = '0;
                route = gop_pkg::E_FRD;
              end
            end
            gop_pkg::PH_RPT: begin
              repeat_left_next = data_byte;
              route = gop_pkg::E_RPT;
            end
            gop_pkg::PH_X, gop_pkg::PH_Y: begin
              if (PT_W'(cu) < pt) begin
                sh = (ph == gop_pkg::PH_X) ? f[gop_pkg::FB_XSHORT] : f[gop_pkg::FB_YSHORT];
                sm = (ph == gop_pkg::PH_X) ? f[gop_pkg::FB_XSAME] : f[gop_pkg::FB_YSAME];
                if (sh) begin
                  delta = sm ? {8'd0, data_byte} : (16'd0 - {8'd0, data_byte});
                  do_store = 1'b1;
                end else if (bs == 16'd0) begin
                  hb = data_byte; bs = 16'd1;
                end else begin
                  delta = {hb, data_byte};
                  do_store = 1'b1;
                end
              end
              if (do_store) begin
                cr = cr + delta;
                pt_waddr = cu[PA_W-1:0];
                x_wdata = {f[gop_pkg::FB_ON], cr};
                y_wdata = cr;
                x_we = (ph == gop_pkg::PH_X);
                y_we = (ph == gop_pkg::PH_Y);
                cu = cu + CU_W'(1);
                bs = '0;
                route = gop_pkg::E_FRD;
              end
            end
            default: begin
            end
          endcase
          if (route == gop_pkg::E_IN &&
              (st_v || end_of_data || ph == gop_pkg::PH_Y || ph == gop_pkg::PH_DRAIN)) begin
            route = gop_pkg::E_FIN;
          end
          phase_next = ph; byte_step_next = bs; high_byte_next = hb; hdr_count_next = hc;
          contour_total_next = ct; point_total_next = pt; instr_remaining_next = ir;
          cursor_next = cu; coord_running_next = cr;
          item_eod_next = end_of_data;
          item_stat_v_next = st_v;
          item_stat_next = st;
        end
      end
      gop_pkg::E_RPT: begin
        if (repeat_left != 8'd0 && PT_W'(cursor) < point_total) begin
          flag_we = 1'b1;
          cursor_next = cursor + CU_W'(1);
          repeat_left_next = repeat_left - 8'd1;
        end else begin
          repeat_left_next = '0;
          if (PT_W'(cursor) >= point_total) begin
            phase_next = gop_pkg::PH_X; cursor_next = '0; coord_running_next = '0;
            byte_step_next = '0;
            route = gop_pkg::E_FRD;
          end else begin
            phase_next = gop_pkg::PH_FLAGS;
            route = gop_pkg::E_FIN;
          end
        end
      end
      gop_pkg::E_FRD: begin
        if (phase == gop_pkg::PH_X || phase == gop_pkg::PH_Y) begin
          if (PT_W'(cursor) >= point_total) begin
            if (phase == gop_pkg::PH_X) begin
              phase_next = gop_pkg::PH_Y; cursor_next = '0; coord_running_next = '0;
              byte_step_next = '0;
            end else begin
              phase_next = gop_pkg::PH_DRAIN;
              route = gop_pkg::E_FIN;
            end
          end else begin
            route = gop_pkg::E_FCHK;
          end
        end else begin
          route = gop_pkg::E_FIN;
        end
      end
      gop_pkg::E_FCHK: begin
        cur_flag_next = flag_rdata;
        sh = (phase == gop_pkg::PH_X) ? flag_rdata[gop_pkg::FB_XSHORT] :
                                        flag_rdata[gop_pkg::FB_YSHORT];
        sm = (phase == gop_pkg::PH_X) ? flag_rdata[gop_pkg::FB_XSAME] :
                                        flag_rdata[gop_pkg::FB_YSAME];
        if (sh || !sm) begin
          route = gop_pkg::E_FIN;
        end else begin
          x_wdata = {flag_rdata[gop_pkg::FB_ON], coord_running};
          x_we = (phase == gop_pkg::PH_X);
          y_we = (phase == gop_pkg::PH_Y);
          cursor_next = cursor + CU_W'(1);
          byte_step_next = '0;
          route = gop_pkg::E_FRD;
        end
      end
      gop_pkg::E_FIN: begin
        if (item_stat_v || (item_eod && phase != gop_pkg::PH_DRAIN &&
                            phase != gop_pkg::PH_IDLE)) begin
          if (out_free) begin
            out_load = 1'b1;
            ld_stat = item_stat_v ? item_stat : gop_pkg::STAT_TRUNCATED;
            phase_next = gop_pkg::PH_IDLE;
            item_stat_v_next = 1'b0;
            route = gop_pkg::E_IN;
          end
        end else if ((phase == gop_pkg::PH_Y && emit_next < cursor) ||
                     (phase == gop_pkg::PH_DRAIN && PT_W'(emit_next) < point_total)) begin
          route = gop_pkg::E_EMIT;
        end else begin
          route = gop_pkg::E_IN;
        end
      end
      gop_pkg::E_EMIT: begin
        if (out_free) begin
          ce = (contour_cursor < contour_total) && (PT_W'(end_rdata) == PT_W'(emit_next));
          out_load = 1'b1;
          ld_x = x_rdata[CW-1:0];
          ld_on = x_rdata[CW];
          ld_y = y_rdata;
          ld_num = 10'(emit_next);
          ld_ce = ce;
          ld_last = (PT_W'(emit_next) + PT_W'(1) == point_total);
          if (ce) begin
            contour_cursor_next = contour_cursor + CC_W'(1);
          end
          emit_next_next = emit_next + CU_W'(1);
          if (PT_W'(emit_next) + PT_W'(1) >= point_total) begin
            phase_next = gop_pkg::PH_IDLE;
          end
          route = gop_pkg::E_IN;
        end
      end
      default: begin
        route = gop_pkg::E_IN;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    case (eng)
      gop_pkg::E_IN, gop_pkg::E_RPT, gop_pkg::E_FRD,
      gop_pkg::E_FCHK, gop_pkg::E_FIN, gop_pkg::E_EMIT: eng_next = route;
      default: eng_next = gop_pkg::E_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eng             <= gop_pkg::E_IN;
      phase           <= gop_pkg::PH_HEADER;
      byte_step       <= '0;
      high_byte       <= '0;
      hdr_count       <= '0;
      contour_total   <= '0;
      point_total     <= '0;
      instr_remaining <= '0;
      repeat_left     <= '0;
      cursor          <= '0;
      coord_running   <= '0;
      contour_cursor  <= '0;
      emit_next       <= '0;
      item_eod        <= 1'b0;
      item_stat_v     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      eng             <= eng_next;
      phase           <= phase_next;
      byte_step       <= byte_step_next;
      high_byte       <= high_byte_next;
      hdr_count       <= hdr_count_next;
      contour_total   <= contour_total_next;
      point_total     <= point_total_next;
      instr_remaining <= instr_remaining_next;
      repeat_left     <= repeat_left_next;
      cursor          <= cursor_next;
      coord_running   <= coord_running_next;
      contour_cursor  <= contour_cursor_next;
      emit_next       <= emit_next_next;
      item_eod        <= item_eod_next;
      item_stat_v     <= item_stat_v_next;
      out_valid       <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    last_flag <= last_flag_next;
    cur_flag  <= cur_flag_next;
    item_stat <= item_stat_next;
    if (out_load) begin
      point_x      <= ld_x;
      point_y      <= ld_y;
      point_number <= ld_num;
      on_curve     <= ld_on;
      contour_end  <= ld_ce;
      last_point   <= ld_last;
      status       <= ld_stat;
    end
  end

`ifndef NO_ASSERTIONS
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != gop_pkg::STAT_POINT |-> last_point)
    else $error("status word without last mark");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == gop_pkg::PH_X || phase == gop_pkg::PH_Y) |-> PT_W'(cursor) <= point_total)
    else $error("cursor beyond point count");

  a_emit_behind: assert property (@(posedge clk) disable iff (rst)
    phase == gop_pkg::PH_Y |-> emit_next <= cursor)
    else $error("emission ahead of decoded y");

  a_fchk_after_frd: assert property (@(posedge clk) disable iff (rst)
    eng == gop_pkg::E_FCHK |-> $past(eng) == gop_pkg::E_FRD)
    else $error("flag check without flag read");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    eng == gop_pkg::E_EMIT && out_load && ld_last |=> phase == gop_pkg::PH_IDLE)
    else $error("decoder not idle after last point");
`endif

endmodule

>>> sim/glyph_outline_point_decoder_tb.sv
`timescale 1ns / 1ps

module glyph_outline_point_decoder_tb;

  typedef struct {
    logic [7:0] data;
    bit         first;
    bit         final_byte;
  } word_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         num;
    logic               on;
    logic               ce;
    logic               last;
    gop_pkg::status_t   st;
  } point_t;

  localparam int NPTS = 1024;
  localparam int NCTR = 64;
  localparam int MAX_DRAIN = 160;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] data_byte = 0;
  logic start_glyph = 0;
  logic end_of_data = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] point_x, point_y;
  logic [9:0] point_number;
  logic on_curve, contour_end, last_point;
  logic [1:0] status;

  glyph_outline_point_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_glyph(start_glyph), .end_of_data(end_of_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .point_number(point_number),
    .on_curve(on_curve), .contour_end(contour_end), .last_point(last_point),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // decoder state mirror
  gop_pkg::phase_t ph;
  logic [15:0] step;
  logic [7:0]  hi;
  int unsigned ctr_total, pt_total, instr_left, cur, run, ccur, emit_n, hdr;
  logic [15:0] end_mem [NCTR];
  logic [5:0]  flag_mem [NPTS];
  logic [15:0] x_mem [NPTS];
  logic [15:0] y_mem [NPTS];

  point_t pending_points[$];
  word_t  seq[$];
  int errors = 0;
  int sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  task automatic restart_glyph();
    ph = gop_pkg::PH_HEADER;
    step = 0; hi = 0; ctr_total = 0; pt_total = 0; instr_left = 0;
    cur = 0; run = 0; ccur = 0; emit_n = 0; hdr = 0;
  endtask

  function automatic bit needs_bytes(logic [5:0] f, bit is_x);
    if (is_x) return f[gop_pkg::FB_XSHORT] || !f[gop_pkg::FB_XSAME];
    return f[gop_pkg::FB_YSHORT] || !f[gop_pkg::FB_YSAME];
  endfunction

  task automatic store_coord(int unsigned delta);
    run = (run + delta) & 32'hffff;
    if (cur < NPTS) begin
      if (ph == gop_pkg::PH_X) x_mem[cur] = run[15:0];
      else y_mem[cur] = run[15:0];
    end
    cur++;
    step = 0;
  endtask

  task automatic begin_coords(gop_pkg::phase_t p);
    ph = p; cur = 0; run = 0; step = 0;
  endtask

  task automatic settle_coords();
    bit is_x;
    while (ph == gop_pkg::PH_X || ph == gop_pkg::PH_Y) begin
      is_x = (ph == gop_pkg::PH_X);
      if (cur >= pt_total) begin
        if (is_x) begin_coords(gop_pkg::PH_Y);
        else begin
          ph = gop_pkg::PH_DRAIN;
          break;
        end
      end else if (needs_bytes(flag_mem[cur], is_x)) break;
      else store_coord(0);
    end
  endtask

  task automatic decode_word(logic [7:0] b, bit first, bit final_byte);
    bit has_st;
    gop_pkg::status_t st;
    int unsigned e, avail, rep;
    logic [5:0] f;
    bit is_x, ce;
    point_t p;
    has_st = 0;
    st = gop_pkg::STAT_POINT;
    if (first) restart_glyph();
    case (ph)
      gop_pkg::PH_HEADER: begin
        if (step == 0) hi = b;
        else if (step == 1) hdr = {16'd0, hi, b};
        step++;
        if (step == 10) begin
          if (hdr == 0 || hdr[15]) begin
            has_st = 1; st = gop_pkg::STAT_COMPOSITE; ph = gop_pkg::PH_IDLE;
          end else if (hdr > NCTR) begin
            has_st = 1; st = gop_pkg::STAT_OVERFLOW; ph = gop_pkg::PH_IDLE;
          end else begin
            ctr_total = hdr; ph = gop_pkg::PH_ENDS; step = 0;
          end
        end
      end
      gop_pkg::PH_ENDS: begin
        if (!step[0]) hi = b;
        else begin
          e = {16'd0, hi, b};
          if ((step >> 1) < NCTR) end_mem[step >> 1] = e[15:0];
          if (e + 1 > pt_total) pt_total = e + 1;
        end
        step++;
        if (step >= 2 * ctr_total) begin
          if (pt_total > NPTS) begin
            has_st = 1; st = gop_pkg::STAT_OVERFLOW; ph = gop_pkg::PH_IDLE;
          end else begin
            ph = gop_pkg::PH_ILEN; step = 0;
          end
        end
      end
      gop_pkg::PH_ILEN: begin
        if (step == 0) begin
          hi = b; step = 1;
        end else begin
          instr_left = {16'd0, hi, b};
          step = 0;
          ph = (instr_left != 0) ? gop_pkg::PH_INSTR : gop_pkg::PH_FLAGS;
        end
      end
      gop_pkg::PH_INSTR: begin
        instr_left--;
        if (instr_left == 0) ph = gop_pkg::PH_FLAGS;
      end
      gop_pkg::PH_FLAGS: begin
        if (cur < pt_total && cur < NPTS) begin
          flag_mem[cur] = b[5:0];
          cur++;
        end
        if (b[gop_pkg::FB_RPT]) ph = gop_pkg::PH_RPT;
        else if (cur >= pt_total) begin_coords(gop_pkg::PH_X);
      end
      gop_pkg::PH_RPT: begin
        rep = {24'd0, b};
        while (rep != 0 && cur < pt_total && cur > 0 && cur < NPTS) begin
          flag_mem[cur] = flag_mem[cur - 1];
          cur++;
          rep--;
        end
        if (cur >= pt_total) begin_coords(gop_pkg::PH_X);
        else ph = gop_pkg::PH_FLAGS;
      end
      gop_pkg::PH_X, gop_pkg::PH_Y: begin
        is_x = (ph == gop_pkg::PH_X);
        if (cur < pt_total) begin
          f = flag_mem[cur];
          if (f[is_x ? gop_pkg::FB_XSHORT : gop_pkg::FB_YSHORT]) begin
            if (f[is_x ? gop_pkg::FB_XSAME : gop_pkg::FB_YSAME]) store_coord({24'd0, b});
            else store_coord((32'h10000 - {24'd0, b}) & 32'hffff);
          end else if (step == 0) begin
            hi = b; step = 1;
          end else store_coord({16'd0, hi, b});
        end
      end
      default: ;
    endcase

    settle_coords();

    if (!has_st && final_byte && int'(ph) <= int'(gop_pkg::PH_Y)) begin
      has_st = 1; st = gop_pkg::STAT_TRUNCATED; ph = gop_pkg::PH_IDLE;
    end

    if (has_st) begin
      p = '{x: 0, y: 0, num: 0, on: 0, ce: 0, last: 1, st: st};
      pending_points.push_back(p);
      return;
    end
    if (ph != gop_pkg::PH_Y && ph != gop_pkg::PH_DRAIN) return;
    avail = (ph == gop_pkg::PH_Y) ? cur : pt_total;
    if (emit_n >= avail || emit_n >= NPTS) return;
    ce = ccur < ctr_total && ccur < NCTR && end_mem[ccur] == emit_n;
    if (ce) ccur++;
    p.x = x_mem[emit_n];
    p.y = y_mem[emit_n];
    p.num = emit_n[9:0];
    p.on = flag_mem[emit_n][gop_pkg::FB_ON];
    p.ce = ce;
    p.last = (emit_n + 1 == pt_total);
    p.st = gop_pkg::STAT_POINT;
    pending_points.push_back(p);
    emit_n++;
    if (emit_n >= pt_total) ph = gop_pkg::PH_IDLE;
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    point_t p;
    if (!rst) begin
      if (in_valid && in_ready) decode_word(data_byte, start_glyph, end_of_data);
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected point, expected none, actual x %0d y %0d status %0d",
                   $time, point_x, point_y, status);
        end else begin
          p = pending_points.pop_front();
          check_field("point_x", p.x, point_x);
          check_field("point_y", p.y, point_y);
          check_field("point_number", p.num, point_number);
          check_field("on_curve", p.on, on_curve);
          check_field("contour_end", p.ce, contour_end);
          check_field("last_point", p.last, last_point);
          check_field("status", p.st, status);
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_word(word_t w);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    data_byte <= w.data;
    start_glyph <= w.first;
    end_of_data <= w.final_byte;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_seq();
    foreach (seq[i]) send_word(seq[i]);
    sent += seq.size();
    seq.delete();
  endtask

  task automatic wait_quiet();
    in_valid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b);
    seq.push_back('{data: b, first: 0, final_byte: 0});
  endtask

  task automatic push_word16(logic [15:0] v);
    push_byte(v[15:8]);
    push_byte(v[7:0]);
  endtask

  task automatic push_header(logic [15:0] nc);
    seq.push_back('{data: nc[15:8], first: 1, final_byte: 0});
    push_byte(nc[7:0]);
    repeat (8) push_byte(8'($urandom));
  endtask

  // whole glyph: ends, instructions, flags with runs, deltas, then drain bytes
  task automatic build_glyph(int nc, int npts, bit shuffle, bit dense);
    logic [15:0] ends_q[$];
    logic [7:0] flg [NPTS];
    logic [7:0] f;
    logic [15:0] tmp;
    int n, c, a, k;
    push_header(16'(nc));
    for (int i = 0; i < nc; i++) ends_q.push_back(16'(((i + 1) * npts) / nc - 1));
    if (shuffle && nc > 1) begin
      a = $urandom_range(0, nc - 1);
      k = $urandom_range(0, nc - 1);
      tmp = ends_q[a]; ends_q[a] = ends_q[k]; ends_q[k] = tmp;
    end
    foreach (ends_q[i]) push_word16(ends_q[i]);
    n = dense ? 0 : $urandom_range(0, 3);
    push_word16(16'(n));
    repeat (n) push_byte(8'($urandom));
    c = 0;
    while (c < npts) begin
      f = dense ? 8'h39 : 8'($urandom);
      if (!dense && $urandom_range(3) != 0) f[gop_pkg::FB_RPT] = 0;
      push_byte(f);
      flg[c] = f;
      c++;
      if (f[gop_pkg::FB_RPT]) begin
        n = dense ? 255 : $urandom_range(0, 5);
        push_byte(8'(n));
        for (int r = 0; r < n && c < npts; r++) begin
          flg[c] = f;
          c++;
        end
      end
    end
    for (int ax = 0; ax < 2; ax++)
      for (int i = 0; i < npts; i++) begin
        f = flg[i];
        if (f[ax ? gop_pkg::FB_YSHORT : gop_pkg::FB_XSHORT]) push_byte(8'($urandom));
        else if (!f[ax ? gop_pkg::FB_YSAME : gop_pkg::FB_XSAME]) push_word16(16'($urandom));
      end
    repeat (npts) push_byte(8'($urandom));
  endtask

  task automatic cut_seq(bit mark_end);
    int k;
    k = $urandom_range(0, seq.size() - 1);
    while (seq.size() > k + 1) void'(seq.pop_back());
    if (mark_end) seq[k].final_byte = 1;
  endtask

  task automatic test_composite();
    push_header(16'h0000);
    push_header(16'hffff);
    push_header(16'h8000);
    send_seq();
  endtask

  task automatic test_overflow();
    push_header(16'(NCTR + 1));
    push_header(16'd1);
    push_word16(16'(NPTS));
    push_header(16'd2);
    push_word16(16'd3);
    push_word16(16'hffff);
    send_seq();
  endtask

  task automatic test_extremes();
    push_header(16'd1);
    push_word16(16'd3);
    push_word16(16'd0);
    push_byte(8'h01);
    push_byte(8'hf6);
    push_byte(8'h0e);
    push_byte(8'h00);
    push_byte(8'h00);
    push_word16(16'h7fff);
    push_byte(8'hff);
    push_byte(8'hff);
    push_word16(16'h8000);
    push_word16(16'h8000);
    push_byte(8'h00);
    push_byte(8'h01);
    push_word16(16'h7fff);
    repeat (3) push_byte(8'hff);
    seq[$].final_byte = 1;
    send_seq();
  endtask

  task automatic test_truncate_restart();
    build_glyph(2, 6, 0, 0);
    cut_seq(1);
    send_seq();
    build_glyph(3, 7, 1, 0);
    cut_seq(0);
    build_glyph(1, 3, 0, 0);
    send_seq();
  endtask

  // full point and contour count, abandoned part way through the drain
  task automatic test_max_size();
    wait_quiet();
    build_glyph(NCTR, NPTS, 0, 1);
    repeat (NPTS - MAX_DRAIN) void'(seq.pop_back());
    send_seq();
  endtask

  task automatic test_random(int target);
    int kind, goal;
    goal = sent + target;
    while (sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 92) begin
        build_glyph($urandom_range(1, 4), 0, 0, 0);
        seq.delete();
        build_glyph($urandom_range(1, 4), $urandom_range(4, 24), 1'($urandom_range(1)), 0);
        if (kind >= 75 && kind < 85) cut_seq(1);
        else if (kind >= 85) cut_seq(0);
      end else begin
        repeat ($urandom_range(1, 6))
          seq.push_back('{data: 8'($urandom), first: ($urandom_range(3) == 0),
                          final_byte: ($urandom_range(7) == 0)});
      end
      send_seq();
    end
  endtask

  initial begin
    restart_glyph();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    gap_pct = 6; stall_pct = 64;
    test_composite();
    test_overflow();
    test_extremes();
    test_truncate_restart();
    test_random(160);
    test_max_size();
    gap_pct = 64; stall_pct = 6;
    test_random(160);
    gap_pct = 0; stall_pct = 0;
    test_random(160);
    in_valid <= 0;
    fork
      begin
        while (pending_points.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        errors++;
      end
    join_any
    disable fork;
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
